/* rtl/annb_pkg.sv */
package annb_pkg;

    localparam int BYTE_W      = 8;
    localparam int HOLD_DEPTH  = 4;    // longest held run: one nonzero byte plus three zeros
    localparam int MAX_EMIT    = 5;    // most results one input byte can release
    localparam int QUEUE_DEPTH = 8;

    localparam int HOLD_CNT_W  = $clog2(HOLD_DEPTH + 1);
    localparam int EMIT_CNT_W  = $clog2(MAX_EMIT + 1);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CODEC_SELECT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEEP_MARKER  = 1'b1;

    // Codec select values
    localparam logic CODEC_H264 = 1'b0;

    // NAL unit types
    localparam logic [4:0] H264_MASK = 5'h1F;
    localparam logic [4:0] H264_SPS  = 5'd7;
    localparam logic [4:0] H264_PPS  = 5'd8;
    localparam logic [4:0] H264_IDR  = 5'd5;
    localparam logic [5:0] H265_VPS  = 6'd32;
    localparam logic [5:0] H265_SPS  = 6'd33;
    localparam logic [5:0] H265_PPS  = 6'd34;
    localparam logic [5:0] H265_IDR_W_RADL = 6'd19;
    localparam logic [5:0] H265_IDR_N_LP   = 6'd20;

    typedef enum logic [2:0] {
        KIND_OTHER = 3'd0,
        KIND_VPS   = 3'd1,
        KIND_SPS   = 3'd2,
        KIND_PPS   = 3'd3,
        KIND_IDR   = 3'd4
    } kind_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic [BYTE_W-1:0] header;
        kind_t             kind;
    } res_t;

    // Results released by one accepted byte, in order from slot 0
    typedef struct packed {
        logic [EMIT_CNT_W-1:0]  n;
        res_t [MAX_EMIT-1:0]    slot;
    } emit_t;

endpackage

/* rtl/annb_parser.sv */
module annb_parser
    import annb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic                   cfg_data,
    input  logic                   in_accept,
    input  logic [BYTE_W-1:0]      in_byte,
    input  logic                   packet_end,
    output emit_t                  emit
);

    logic                  codec_sel_reg;
    logic                  keep_marker_reg;
    logic [HOLD_DEPTH-1:0][BYTE_W-1:0] hold_reg, hold_mid, hold_next;
    logic [HOLD_CNT_W-1:0] hold_cnt_reg, cnt_mid, hold_cnt_next;
    logic [1:0]            zero_run_reg, zr_mid, zero_run_next;
    logic                  in_unit_reg, iu_mid, in_unit_next;
    logic                  header_wait_reg, hw_mid, header_wait_next;
    logic [BYTE_W-1:0]     header_reg, header_next;
    logic                  first_pend_reg, fp_mid, first_pend_next;

    logic                  is_zero;
    logic                  is_marker;
    logic                  start;
    logic [EMIT_CNT_W-1:0] na;
    logic [EMIT_CNT_W-1:0] nb;
    logic                  a_first;
    logic                  a_last;
    kind_t                 kind;

    function automatic kind_t kind_of(input logic codec, input logic [BYTE_W-1:0] h);
        logic [4:0] t4;
        logic [5:0] t5;
        kind_t      k;
        t4 = h[4:0] & H264_MASK;
        t5 = h[6:1];
        k  = KIND_OTHER;
        if (codec == CODEC_H264) begin
            if (t4 == H264_SPS)      k = KIND_SPS;
            else if (t4 == H264_PPS) k = KIND_PPS;
            else if (t4 == H264_IDR) k = KIND_IDR;
        end else begin
            if (t5 == H265_VPS)      k = KIND_VPS;
            else if (t5 == H265_SPS) k = KIND_SPS;
            else if (t5 == H265_PPS) k = KIND_PPS;
            else if (t5 == H265_IDR_W_RADL || t5 == H265_IDR_N_LP) k = KIND_IDR;
        end
        return k;
    endfunction

    assign is_zero   = (in_byte == '0);
    assign is_marker = (in_byte == BYTE_W'(1)) && zero_run_reg[1];

    always_comb begin
        logic [EMIT_CNT_W-1:0] j;
        j           = '0;
        hold_mid    = hold_reg;
        cnt_mid     = hold_cnt_reg;
        zr_mid      = zero_run_reg;
        iu_mid      = in_unit_reg;
        hw_mid      = header_wait_reg;
        header_next = header_reg;
        fp_mid      = first_pend_reg;
        na          = '0;
        a_first     = 1'b0;
        a_last      = 1'b0;
        start       = 1'b0;

        if (!in_unit_reg) begin
            if (is_zero) begin
                if (zero_run_reg != 2'd3) zr_mid = zero_run_reg + 2'd1;
            end else if (is_marker) begin
                start = 1'b1;
            end else begin
                zr_mid = '0;
            end
        end else if (header_wait_reg) begin
            // release any kept marker, header becomes the only held byte
            header_next = in_byte;
            na          = EMIT_CNT_W'(hold_cnt_reg);
            a_first     = 1'b1;
            fp_mid      = (hold_cnt_reg == '0);
            hold_mid[0] = in_byte;
            cnt_mid     = HOLD_CNT_W'(1);
            zr_mid      = '0;
            hw_mid      = 1'b0;
        end else begin
            if (is_zero) begin
                if (zero_run_reg != 2'd3) begin
                    hold_mid[hold_cnt_reg[1:0]] = '0;
                    cnt_mid = hold_cnt_reg + HOLD_CNT_W'(1);
                    zr_mid  = zero_run_reg + 2'd1;
                end else begin
                    // only the last three zeros can join a marker: release the oldest
                    na      = EMIT_CNT_W'(1);
                    a_first = first_pend_reg;
                    fp_mid  = 1'b0;
                    for (int i = 0; i < HOLD_DEPTH - 1; i++) hold_mid[i] = hold_reg[i+1];
                    hold_mid[HOLD_DEPTH-1] = '0;
                end
            end else if (is_marker) begin
                na      = EMIT_CNT_W'(1);
                a_first = first_pend_reg;
                a_last  = 1'b1;
                fp_mid  = 1'b0;
                start   = 1'b1;
            end else begin
                na          = EMIT_CNT_W'(hold_cnt_reg);
                a_first     = first_pend_reg;
                fp_mid      = (hold_cnt_reg != '0) ? 1'b0 : first_pend_reg;
                hold_mid[0] = in_byte;
                cnt_mid     = HOLD_CNT_W'(1);
                zr_mid      = '0;
            end
        end

        if (start) begin
            iu_mid  = 1'b1;
            hw_mid  = 1'b1;
            zr_mid  = '0;
            cnt_mid = keep_marker_reg ? (HOLD_CNT_W'(zero_run_reg) + HOLD_CNT_W'(1)) : '0;
            for (int i = 0; i < HOLD_DEPTH; i++) begin
                hold_mid[i] = (2'(i) == zero_run_reg) ? BYTE_W'(1) : '0;
            end
        end

        // packet end flushes the line and closes the open unit
        nb = (packet_end && iu_mid && !hw_mid) ? EMIT_CNT_W'(cnt_mid) : '0;

        hold_next        = hold_mid;
        header_wait_next = packet_end ? 1'b0 : hw_mid;
        in_unit_next     = packet_end ? 1'b0 : iu_mid;
        hold_cnt_next    = packet_end ? '0 : cnt_mid;
        zero_run_next    = packet_end ? '0 : zr_mid;
        first_pend_next  = packet_end ? 1'b0 : fp_mid;

        kind   = kind_of(codec_sel_reg, header_next);
        emit.n = in_accept ? EMIT_CNT_W'(na + nb) : '0;
        for (int k = 0; k < MAX_EMIT; k++) begin
            emit.slot[k].header = header_next;
            emit.slot[k].kind   = kind;
            if (EMIT_CNT_W'(k) < na) begin
                emit.slot[k].data  = hold_reg[2'(k)];
                emit.slot[k].first = (k == 0) && a_first;
                emit.slot[k].last  = a_last;
            end else begin
                j = EMIT_CNT_W'(k) - na;
                emit.slot[k].data  = hold_mid[j[1:0]];
                emit.slot[k].first = (j == '0) && fp_mid;
                emit.slot[k].last  = (j == EMIT_CNT_W'(cnt_mid) - EMIT_CNT_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codec_sel_reg   <= 1'b0;
            keep_marker_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_CODEC_SELECT: codec_sel_reg   <= cfg_data;
                CFG_KEEP_MARKER:  keep_marker_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_cnt_reg    <= '0;
            zero_run_reg    <= '0;
            in_unit_reg     <= 1'b0;
            header_wait_reg <= 1'b0;
            header_reg      <= '0;
            first_pend_reg  <= 1'b0;
        end else if (in_accept) begin
            hold_cnt_reg    <= hold_cnt_next;
            zero_run_reg    <= zero_run_next;
            in_unit_reg     <= in_unit_next;
            header_wait_reg <= header_wait_next;
            header_reg      <= header_next;
            first_pend_reg  <= first_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            hold_reg <= hold_next;
        end
    end

`ifndef ASSERT_OFF
    a_wait_in_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        header_wait_reg |-> in_unit_reg)
        else $error("header wait outside a unit");

    a_search_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_unit_reg |-> (hold_cnt_reg == '0))
        else $error("bytes held while searching");

    a_body_zeros: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_unit_reg && !header_wait_reg) |->
            (HOLD_CNT_W'(zero_run_reg) + HOLD_CNT_W'(1) == hold_cnt_reg))
        else $error("hold line out of step with zero run");
`endif

endmodule

/* rtl/annb_out_queue.sv */
module annb_out_queue
    import annb_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  emit_t emit,
    output logic  room,
    output logic  head_valid,
    input  logic  head_ready,
    output res_t  head
);

    localparam logic [QUEUE_CNT_W-1:0] ROOM_LIMIT = QUEUE_CNT_W'(QUEUE_DEPTH - MAX_EMIT);

    res_t [QUEUE_DEPTH-1:0] q_reg, q_next;
    logic [QUEUE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [QUEUE_CNT_W-1:0] base;
    logic                   pop;

    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[0];
    assign room       = (cnt_reg <= ROOM_LIMIT);
    assign pop        = head_valid && head_ready;
    assign base       = cnt_reg - QUEUE_CNT_W'(pop);
    assign cnt_next   = base + QUEUE_CNT_W'(emit.n);

    always_comb begin
        logic [QUEUE_CNT_W-1:0] off;
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
            // advance on a transfer, then append new results behind the survivors
            if (pop && (j + 1 < QUEUE_DEPTH)) q_next[j] = q_reg[(j + 1) % QUEUE_DEPTH];
            else                              q_next[j] = q_reg[j];
            off = QUEUE_CNT_W'(j) - base;
            if ((QUEUE_CNT_W'(j) >= base) && (off < QUEUE_CNT_W'(emit.n))) begin
                q_next[j] = emit.slot[off[EMIT_CNT_W-1:0]];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("output queue overflow");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && emit.n == '0) |=> (cnt_reg == $past(cnt_reg) - QUEUE_CNT_W'(1)))
        else $error("queue count wrong after transfer");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit.n != '0) |=> head_valid)
        else $error("pushed results not presented");
`endif

endmodule

/* rtl/annexb_nal_unit_splitter.sv */
// Channel  Direction  Handshake             Payload
// s_       in         s_tvalid / s_tready   s_tdata = in_byte, s_tlast = packet_end
// m_       out        m_tvalid / m_tready   m_tdata = out_byte, unit_header;
//                                           m_tlast = unit_last; m_tuser = unit_first, unit_kind
// cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data (codec_select, keep_marker)
//
// One input byte is taken per cycle while the output queue holds at most three results;
// one byte releases up to five results into the eight-entry queue in the same cycle.
// Results leave one per cycle, so a stalled m_ side fills the queue and then holds s_tready low.
// Reset is synchronous and clears the control state only; there is no clearing pass.
// cfg_ready is always high.
module annexb_nal_unit_splitter
    import annb_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] in_byte
    input  logic                   s_tlast,   // packet_end

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [15:0]            m_tdata,   // [7:0] out_byte, [15:8] unit_header
    output logic                   m_tlast,   // unit_last
    output logic [7:0]             m_tuser,   // [0] unit_first, [3:1] unit_kind, [7:4] zero

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic                   cfg_data
);

    emit_t emit;
    res_t  head;
    logic  room;
    logic  in_accept;

    assign s_tready  = room;
    assign in_accept = s_tvalid && room;
    assign cfg_ready = 1'b1;

    annb_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .packet_end (s_tlast),
        .emit       (emit)
    );

    annb_out_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .emit       (emit),
        .room       (room),
        .head_valid (m_tvalid),
        .head_ready (m_tready),
        .head       (head)
    );

    assign m_tdata = {head.header, head.data};
    assign m_tlast = head.last;
    assign m_tuser = {4'b0000, head.kind, head.first};

endmodule
